/* rtl/rrr_pkg.sv */
// ----------------------------------------------------------------------------
// rrr_pkg
// Shared types, codes and constants of the reliable response retransmitter.
// ----------------------------------------------------------------------------
package rrr_pkg;

   // Item codes of the request channel.
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_ACK   = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;
   localparam logic [1:0] FUNC_QUERY = 2'd3;

   // Event codes of the response channel.
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_SEND    = 3'd1;
   localparam logic [2:0] EV_RETX    = 3'd2;
   localparam logic [2:0] EV_TIMEOUT = 3'd3;
   localparam logic [2:0] EV_BUSY    = 3'd4;
   localparam logic [2:0] EV_MATCH   = 3'd5;
   localparam logic [2:0] EV_NOMATCH = 3'd6;
   localparam logic [2:0] EV_SEQ     = 3'd7;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_T1_MS        = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_RSEQ = 8'd1;

   localparam logic [11:0] T1_MS_RESET        = 12'd500;
   localparam logic [30:0] INITIAL_RSEQ_RESET = 31'd1;

   // Timer constants.
   localparam logic [8:0] MAX_TOTAL_MULT = 9'd64;
   localparam logic [7:0] BACKOFF_FACTOR = 8'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  txn_id;
      logic [31:0] req_cseq;
      logic [3:0]  req_method;
      logic [31:0] resp_rseq;
      logic        rack_present;
      logic [31:0] rack_cseq;
      logic [3:0]  rack_method;
      logic [31:0] rack_rseq;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  event_txn;
      logic [31:0] seq_value;
   } rsp_type;

   typedef struct packed {
      logic                   en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_wr_type;

endpackage

/* rtl/rrr_engine.sv */
// ----------------------------------------------------------------------------
// rrr_engine
// Transaction state, retransmission timer and sequence counter. Evaluates one
// item per cycle when fired without a CSR write, returning its result beat.
// ----------------------------------------------------------------------------
module rrr_engine (
   input  logic                clock,
   input  logic                reset,
   input  rrr_pkg::csr_wr_type csr_wr,
   input  logic                fire,
   input  rrr_pkg::req_type    item,
   output rrr_pkg::rsp_type    result
);
   import rrr_pkg::*;

   logic [11:0] t1_ff,        t1_in;
   logic [30:0] init_rseq_ff, init_rseq_in;
   logic        busy_ff,      busy_in;
   logic        txn_valid_ff, txn_valid_in;
   logic [7:0]  cur_txn_ff,   cur_txn_in;
   logic [31:0] cseq_ff,      cseq_in;
   logic [3:0]  method_ff,    method_in;
   logic [31:0] rseq_ff,      rseq_in;
   logic [31:0] seq_ff,       seq_in;
   logic [7:0]  backoff_ff,   backoff_in;
   logic [6:0]  total_ff,     total_in;
   logic        final_ff,     final_in;
   logic [17:0] count_ff,     count_in;
   logic        armed_ff,     armed_in;

   logic [8:0]  sum;
   logic        sum_fits;
   logic [7:0]  mul_a;
   logic [19:0] prod;
   logic        ack_match;
   logic        busy_after;
   logic [31:0] seq_next;

   // The next interval is either the doubled backoff or the remainder up to
   // the full multiple; one multiplier serves both.
   assign sum      = {2'b00, total_ff} + {1'b0, backoff_ff};
   assign sum_fits = (sum <= MAX_TOTAL_MULT);
   assign mul_a    = sum_fits ? backoff_ff : 8'(MAX_TOTAL_MULT - {2'b00, total_ff});
   assign prod     = mul_a * t1_ff;

   assign ack_match = txn_valid_ff && item.rack_present
                      && (item.rack_cseq == cseq_ff)
                      && (item.rack_method == method_ff)
                      && (item.rack_rseq == rseq_ff);

   assign busy_after = final_ff ? 1'b0 : busy_ff;
   assign seq_next   = seq_ff + 32'd1;

   always_comb begin
      t1_in        = t1_ff;
      init_rseq_in = init_rseq_ff;
      busy_in      = busy_ff;
      txn_valid_in = txn_valid_ff;
      cur_txn_in   = cur_txn_ff;
      cseq_in      = cseq_ff;
      method_in    = method_ff;
      rseq_in      = rseq_ff;
      seq_in       = seq_ff;
      backoff_in   = backoff_ff;
      total_in     = total_ff;
      final_in     = final_ff;
      count_in     = count_ff;
      armed_in     = armed_ff;
      result       = '0;

      if (csr_wr.en) begin
         if (csr_wr.index == CSR_T1_MS) begin
            t1_in = csr_wr.data[11:0];
         end else if (csr_wr.index == CSR_INITIAL_RSEQ) begin
            init_rseq_in = csr_wr.data[30:0];
            seq_in       = {1'b0, csr_wr.data[30:0]};
         end
      end else if (fire) begin
         case (item.func)
            FUNC_START: begin
               if (busy_ff) begin
                  result.event_res = EV_BUSY;
                  result.event_txn = item.txn_id;
               end else begin
                  cur_txn_in       = item.txn_id;
                  cseq_in          = item.req_cseq;
                  method_in        = item.req_method;
                  rseq_in          = item.resp_rseq;
                  txn_valid_in     = 1'b1;
                  busy_in          = 1'b1;
                  total_in         = '0;
                  final_in         = 1'b0;
                  count_in         = {6'b0, t1_ff};
                  armed_in         = 1'b1;
                  backoff_in       = BACKOFF_FACTOR;
                  result.event_res = EV_SEND;
                  result.event_txn = item.txn_id;
               end
            end
            FUNC_ACK: begin
               result.event_txn = cur_txn_ff;
               if (ack_match) begin
                  armed_in         = 1'b0;
                  busy_in          = 1'b0;
                  result.event_res = EV_MATCH;
               end else begin
                  result.event_res = EV_NOMATCH;
               end
            end
            FUNC_TICK: begin
               if (armed_ff) begin
                  if (count_ff <= 18'd1) begin
                     count_in         = '0;
                     armed_in         = 1'b0;
                     busy_in          = busy_after;
                     result.event_txn = cur_txn_ff;
                     result.event_res = final_ff ? EV_TIMEOUT : EV_RETX;
                     if ((backoff_ff <= 8'(MAX_TOTAL_MULT)) && busy_after) begin
                        if (sum_fits) begin
                           total_in = sum[6:0];
                        end else begin
                           final_in = 1'b1;
                        end
                        count_in   = prod[17:0];
                        armed_in   = 1'b1;
                        backoff_in = 8'(backoff_ff * BACKOFF_FACTOR);
                     end
                  end else begin
                     count_in = count_ff - 18'd1;
                  end
               end
            end
            FUNC_QUERY: begin
               result.event_res = EV_SEQ;
               result.event_txn = item.txn_id;
               if (!busy_ff) begin
                  if (txn_valid_ff && (item.txn_id == cur_txn_ff)) begin
                     seq_in           = seq_next;
                     result.seq_value = seq_next;
                  end else begin
                     result.seq_value = seq_ff;
                  end
               end
            end
            default: begin
               result = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cseq_ff   <= cseq_in;
      method_ff <= method_in;
      rseq_ff   <= rseq_in;
      if (reset) begin
         t1_ff        <= T1_MS_RESET;
         init_rseq_ff <= INITIAL_RSEQ_RESET;
         busy_ff      <= 1'b0;
         txn_valid_ff <= 1'b0;
         cur_txn_ff   <= '0;
         seq_ff       <= {1'b0, INITIAL_RSEQ_RESET};
         backoff_ff   <= 8'd1;
         total_ff     <= '0;
         final_ff     <= 1'b0;
         count_ff     <= '0;
         armed_ff     <= 1'b0;
      end else begin
         t1_ff        <= t1_in;
         init_rseq_ff <= init_rseq_in;
         busy_ff      <= busy_in;
         txn_valid_ff <= txn_valid_in;
         cur_txn_ff   <= cur_txn_in;
         seq_ff       <= seq_in;
         backoff_ff   <= backoff_in;
         total_ff     <= total_in;
         final_ff     <= final_in;
         count_ff     <= count_in;
         armed_ff     <= armed_in;
      end
   end

endmodule

/* rtl/reliable_response_retransmit.sv */
// ----------------------------------------------------------------------------
// reliable_response_retransmit
// Sender of reliable provisional responses with retransmission timer.
// ----------------------------------------------------------------------------
// Every request beat yields exactly one response beat. A beat is captured in
// an input register, evaluated against the transaction state and written to
// the output register, so one beat per cycle is sustained while rsp_stall is
// low; each response beat passes the input and then the output register.
// The input register keeps accepting while the output register is full as
// long as the output is being taken. Configuration writes are taken at once
// and must only be issued while no beat is in flight; writing the initial
// RSeq also reloads the sequence counter. Ticks drive a millisecond countdown.
module reliable_response_retransmit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rrr_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rrr_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rrr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rrr_pkg::CSR_DATA_W-1:0]       csr_data
);
   import rrr_pkg::*;

   logic       in_valid_ff,  in_valid_in;
   req_type    in_item_ff,   in_item_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_item_ff,  out_item_in;

   logic       advance;
   logic       fire;
   rsp_type    result;
   csr_wr_type csr_wr;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   assign csr_wr.en    = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   rrr_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_item_in = req_payload;
         end
      end
      if (advance) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            out_item_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

/* verif/rrr_tracker_pkg.sv */
// ----------------------------------------------------------------------------
// rrr_tracker_pkg
// Predicts the event of every request beat of the reliable response
// retransmitter and checks the response beats against those predictions.
// ----------------------------------------------------------------------------
package rrr_tracker_pkg;

   import rrr_pkg::*;

   class retransmit_tracker;

      // Register copies.
      bit [11:0]   t1_ms;
      bit [30:0]   first_rseq;

      // Transaction and timer state.
      bit          busy;
      bit          txn_seen;
      bit          final_wait;
      bit          armed;
      bit [7:0]    cur_txn;
      bit [31:0]   held_cseq;
      bit [3:0]    held_method;
      bit [31:0]   held_rseq;
      bit [31:0]   seq_counter;
      int unsigned backoff;
      int unsigned total;
      bit [17:0]   countdown;

      int unsigned failures;
      rsp_type     expected_events[$];

      function new();
         t1_ms       = T1_MS_RESET;
         first_rseq  = INITIAL_RSEQ_RESET;
         seq_counter = {1'b0, INITIAL_RSEQ_RESET};
         backoff     = 1;
         total       = 0;
         busy        = 1'b0;
         txn_seen    = 1'b0;
         final_wait  = 1'b0;
         armed       = 1'b0;
         cur_txn     = '0;
         held_cseq   = '0;
         held_method = '0;
         held_rseq   = '0;
         countdown   = '0;
         failures    = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         if (index == CSR_T1_MS) begin
            t1_ms = data[11:0];
         end else if (index == CSR_INITIAL_RSEQ) begin
            first_rseq  = data[30:0];
            seq_counter = {1'b0, data[30:0]};
         end
      endfunction

      // The countdown has run out: retransmit and re-arm with the doubled
      // interval or with what is left of 64 times T1, or give up on the timeout.
      function rsp_type expire();
         rsp_type     e;
         int unsigned sum;
         e = '0;
         armed = 1'b0;
         e.event_txn = cur_txn;
         if (!final_wait) begin
            e.event_res = EV_RETX;
         end else begin
            e.event_res = EV_TIMEOUT;
            busy = 1'b0;
         end
         if (backoff <= MAX_TOTAL_MULT && busy) begin
            sum = total + backoff;
            if (sum <= MAX_TOTAL_MULT) begin
               total     = sum;
               countdown = 18'(backoff * t1_ms);
            end else begin
               countdown  = 18'((MAX_TOTAL_MULT - total) * t1_ms);
               final_wait = 1'b1;
            end
            armed   = 1'b1;
            backoff = (backoff * BACKOFF_FACTOR) & 32'hFF;
         end
         return e;
      endfunction

      function void take_request(req_type r);
         rsp_type e;
         bit      hit;
         e = '0;
         case (r.func)
            FUNC_START: begin
               e.event_txn = r.txn_id;
               if (busy) begin
                  e.event_res = EV_BUSY;
               end else begin
                  cur_txn     = r.txn_id;
                  held_cseq   = r.req_cseq;
                  held_method = r.req_method;
                  held_rseq   = r.resp_rseq;
                  txn_seen    = 1'b1;
                  busy        = 1'b1;
                  total       = 0;
                  final_wait  = 1'b0;
                  countdown   = 18'(t1_ms);
                  armed       = 1'b1;
                  backoff     = BACKOFF_FACTOR;
                  e.event_res = EV_SEND;
               end
            end
            FUNC_ACK: begin
               hit = txn_seen && r.rack_present && r.rack_cseq == held_cseq
                     && r.rack_method == held_method && r.rack_rseq == held_rseq;
               e.event_txn = cur_txn;
               if (hit) begin
                  armed = 1'b0;
                  busy  = 1'b0;
                  e.event_res = EV_MATCH;
               end else begin
                  e.event_res = EV_NOMATCH;
               end
            end
            FUNC_TICK: begin
               if (armed) begin
                  if (countdown <= 1) begin
                     countdown = '0;
                     e = expire();
                  end else begin
                     countdown = countdown - 1'b1;
                  end
               end
            end
            FUNC_QUERY: begin
               e.event_res = EV_SEQ;
               e.event_txn = r.txn_id;
               if (!busy) begin
                  if (txn_seen && r.txn_id == cur_txn) seq_counter = seq_counter + 1;
                  e.seq_value = seq_counter;
               end
            end
            default: begin
               e = '0;
            end
         endcase
         expected_events.push_back(e);
      endfunction

      function void check_event(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            $error("response beat with nothing expected: %s %0d %s %0d %s %0d",
                   "event_res", got.event_res, "event_txn", got.event_txn,
                   "seq_value", got.seq_value);
            failures++;
            return;
         end
         want = expected_events.pop_front();
         if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
            failures++;
         end
         if (got.event_txn !== want.event_txn) begin
            $error("event_txn: expected %0d, got %0d", want.event_txn, got.event_txn);
            failures++;
         end
         if (got.seq_value !== want.seq_value) begin
            $error("seq_value: expected %0d, got %0d", want.seq_value, got.seq_value);
            failures++;
         end
      endfunction

   endclass

endpackage

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives start, acknowledgement, tick and query beats into the reliable
// response retransmitter under random idling and back-pressure, across
// several timer settings, and checks every response beat against a
// cycle-free prediction of the retransmission and sequence logic.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import rrr_pkg::*;
   import rrr_tracker_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   retransmit_tracker tracker = new();

   int unsigned items_sent;
   int unsigned cycle_count;
   int unsigned stall_left;
   int unsigned hold_off;
   bit          tx_gaps_on;
   bit          rx_gaps_on;

   reliable_response_retransmit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: a requested hold-off overrides the usual random stalls.
   always @(negedge clock) begin
      if (hold_off != 0) begin
         stall_left = hold_off;
         hold_off   = 0;
      end else if (stall_left == 0 && rx_gaps_on && $urandom_range(3) == 0) begin
         stall_left = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_event(rsp_payload);
   end

   function automatic int pick_gap();
      int roll;
      if (!tx_gaps_on) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_req();
      req_type r;
      r.func         = 2'($urandom_range(3));
      r.txn_id       = 8'($urandom_range(255));
      r.req_cseq     = pick_word();
      r.req_method   = 4'($urandom_range(15));
      r.resp_rseq    = pick_word();
      r.rack_present = 1'($urandom_range(1));
      r.rack_cseq    = pick_word();
      r.rack_method  = 4'($urandom_range(15));
      r.rack_rseq    = pick_word();
      return r;
   endfunction

   function automatic req_type build_req(logic [1:0] func, logic [7:0] txn,
                                         logic [31:0] cseq, logic [3:0] method,
                                         logic [31:0] rseq, logic present,
                                         logic [31:0] rcseq, logic [3:0] rmethod,
                                         logic [31:0] rrseq);
      req_type r;
      r = '{func, txn, cseq, method, rseq, present, rcseq, rmethod, rrseq};
      return r;
   endfunction

   function automatic req_type matching_ack();
      req_type r;
      r = random_req();
      r.func         = FUNC_ACK;
      r.rack_present = 1'b1;
      r.rack_cseq    = tracker.held_cseq;
      r.rack_method  = tracker.held_method;
      r.rack_rseq    = tracker.held_rseq;
      return r;
   endfunction

   function automatic req_type broken_ack();
      req_type r;
      r = matching_ack();
      case ($urandom_range(4))
         0: r.rack_present = 1'b0;
         1: r.rack_cseq   = r.rack_cseq ^ (32'd1 << $urandom_range(31));
         2: r.rack_method = r.rack_method ^ (4'd1 << $urandom_range(3));
         3: r.rack_rseq   = r.rack_rseq ^ (32'd1 << $urandom_range(31));
         default: begin
            r.rack_cseq = pick_word();
            r.rack_rseq = pick_word();
         end
      endcase
      return r;
   endfunction

   task automatic send_item(input req_type r, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      tracker.take_request(r);
      items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.expected_events.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timer_config(input logic [11:0] t1, input logic [30:0] rseq);
      wait_idle();
      repeat (3) @(posedge clock);
      write_csr(CSR_T1_MS, {20'd0, t1});
      write_csr(CSR_INITIAL_RSEQ, {1'b0, rseq});
   endtask

   // One transaction: a start, then mostly ticks with queries, stray
   // acknowledgements and refused starts mixed in, ended by a matching
   // acknowledgement or by the timeout, followed by a few queries.
   task automatic run_episode(input int cap);
      req_type r;
      int      n;
      int      roll;
      int      ack_at;
      if (tracker.busy) send_item(matching_ack(), pick_gap());
      r = random_req();
      r.func = FUNC_START;
      send_item(r, pick_gap());
      ack_at = ($urandom_range(2) == 0) ? $urandom_range(1, 60) : cap;
      n = 0;
      while (tracker.busy && n < cap) begin
         roll = $urandom_range(99);
         r = random_req();
         if (n == ack_at) begin
            r = matching_ack();
         end else if (roll < 58) begin
            r.func = FUNC_TICK;
         end else if (roll < 70) begin
            r.func = FUNC_QUERY;
            if ($urandom_range(2) != 0) r.txn_id = tracker.cur_txn;
         end else if (roll < 85) begin
            r = broken_ack();
         end else if (roll < 90) begin
            r.func = FUNC_START;
         end
         send_item(r, pick_gap());
         n++;
      end
      if (tracker.busy) send_item(matching_ack(), pick_gap());
      repeat ($urandom_range(1, 4)) begin
         r = random_req();
         r.func = FUNC_QUERY;
         if ($urandom_range(3) != 0) r.txn_id = tracker.cur_txn;
         send_item(r, pick_gap());
      end
   endtask

   task automatic run_phase(input int unsigned count, input int cap);
      int unsigned goal;
      goal = items_sent + count;
      while (items_sent < goal) run_episode(cap);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      tx_gaps_on  = 1'b0;
      rx_gaps_on  = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Before any start: query, acknowledgement and tick at reset settings.
      send_item(build_req(FUNC_QUERY, 8'h00, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(build_req(FUNC_ACK, 8'h00, 0, 0, 0, 1, 0, 0, 0), 0);
      send_item(build_req(FUNC_TICK, 8'h00, 0, 0, 0, 0, 0, 0, 0), 0);

      // A zero interval expires on every tick, so the whole backoff runs
      // out to the timeout in a handful of ticks.
      set_timer_config(12'd0, 31'h7FFF_FFFF);
      send_item(build_req(FUNC_START, 8'h5A, 0, 0, 0, 0, 0, 0, 0), 0);
      repeat (8) send_item(build_req(FUNC_TICK, 8'h00, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(build_req(FUNC_QUERY, 8'h5A, 0, 0, 0, 0, 0, 0, 0), 0);

      set_timer_config(12'd1, 31'd1);
      send_item(build_req(FUNC_START, 8'hFF, '1, 4'hF, '1, 0, 0, 0, 0), 0);
      send_item(build_req(FUNC_START, 8'h12, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(build_req(FUNC_QUERY, 8'hFF, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(build_req(FUNC_ACK, 8'h00, 0, 0, 0, 0, '1, 4'hF, '1), 0);
      send_item(build_req(FUNC_ACK, 8'h00, 0, 0, 0, 1, 32'hFFFF_FFFE, 4'hF, '1), 0);
      send_item(build_req(FUNC_ACK, 8'h00, 0, 0, 0, 1, '1, 4'h7, '1), 0);
      send_item(build_req(FUNC_ACK, 8'h00, 0, 0, 0, 1, '1, 4'hF, 32'h7FFF_FFFF), 0);
      send_item(build_req(FUNC_TICK, 8'h00, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(build_req(FUNC_ACK, 8'h00, 0, 0, 0, 1, '1, 4'hF, '1), 0);
      send_item(build_req(FUNC_ACK, 8'h00, 0, 0, 0, 1, '1, 4'hF, '1), 0);
      send_item(build_req(FUNC_TICK, 8'h00, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(build_req(FUNC_QUERY, 8'hFF, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(build_req(FUNC_QUERY, 8'h00, 0, 0, 0, 0, 0, 0, 0), 0);

      set_timer_config(12'd1, 31'($urandom_range(1, 32'h7FFF_FFFF)));
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
      run_phase(130, 150);

      // A stretch with no idling on either side.
      set_timer_config(12'd2, 31'd1);
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      run_phase(100, 250);

      // The receiver holds off for a long stretch while beats keep coming,
      // then the sender waits for every outstanding response.
      set_timer_config(12'd4095, 31'h7FFF_FFFF);
      rx_gaps_on = 1'b1;
      hold_off = 300;
      repeat (40) send_item(random_req(), 0);
      wait_idle();
      tx_gaps_on = 1'b1;
      run_phase(60, 40);

      set_timer_config(12'($urandom_range(1, 3)), 31'($urandom_range(1, 32'h7FFF_FFFF)));
      rx_gaps_on = 1'b0;
      run_phase(110, 150);

      set_timer_config(12'd1, 31'($urandom_range(1, 32'h7FFF_FFFF)));
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b1;
      run_phase(100, 150);

      set_timer_config(12'($urandom_range(5, 4094)), 31'($urandom_range(1, 32'h7FFF_FFFF)));
      tx_gaps_on = 1'b1;
      run_phase(60, 60);

      wait_idle();
      repeat (10) @(posedge clock);
      if (tracker.failures == 0 && tracker.expected_events.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/rrr_pkg.sv
rtl/rrr_engine.sv
rtl/reliable_response_retransmit.sv
verif/rrr_tracker_pkg.sv
verif/testbench.sv
